// File: rtl/gble_pkg.sv
`default_nettype none

package gble_pkg;

   // Text store size and the widths that follow from it.
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int SUM_W    = CNT_W + 1;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [2:0]        mode_type;
   typedef logic [7:0]        char_type;
   typedef logic [9:0]        pos_type;
   typedef logic [10:0]       len_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam mode_type MODE_INSERT = 3'd0;
   localparam mode_type MODE_LEFT   = 3'd1;
   localparam mode_type MODE_RIGHT  = 3'd2;
   localparam mode_type MODE_BACK   = 3'd3;
   localparam mode_type MODE_READ   = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BOUNDARY = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_RANGE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_LEFT,
      OP_RIGHT,
      OP_BACK,
      OP_READ,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type   op;
      char_type ch;
      pos_type  pos;
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DATA
   } back_state_type;

   function automatic op_type decode_mode(input mode_type mode);
      op_type op;
      case (mode)
         MODE_INSERT: op = OP_INSERT;
         MODE_LEFT:   op = OP_LEFT;
         MODE_RIGHT:  op = OP_RIGHT;
         MODE_BACK:   op = OP_BACK;
         MODE_READ:   op = OP_READ;
         default:     op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// File: rtl/gble_req_if.sv
`default_nettype none

interface gble_req_if;
   import gble_pkg::*;

   logic     valid;
   logic     ready;
   mode_type mode;
   char_type char_in;
   pos_type  position;

   modport source (output valid, output mode, output char_in, output position, input ready);
   modport sink   (input valid, input mode, input char_in, input position, output ready);
endinterface

`default_nettype wire

// File: rtl/gble_rsp_if.sv
`default_nettype none

interface gble_rsp_if;
   import gble_pkg::*;

   logic       valid;
   logic       ready;
   char_type   char_out;
   len_type    text_length;
   len_type    cursor;
   status_type status;

   modport source (output valid, output char_out, output text_length, output cursor,
                   output status, input ready);
   modport sink   (input valid, input char_out, input text_length, input cursor,
                   input status, output ready);
endinterface

`default_nettype wire

// File: rtl/gble_front.sv
`default_nettype none

module gble_front (
   input  wire logic              clock,
   input  wire logic              reset,
   gble_req_if.sink               req_ch,
   input  wire logic              q_full,
   output logic                   push,
   output gble_pkg::cmd_type      push_cmd
);
   import gble_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type cmd_ff;
   logic    take;

   // The holding register drains into the queue whenever there is room.
   assign push         = hold_valid_ff && !q_full;
   assign req_ch.ready = !hold_valid_ff || push;
   assign take         = req_ch.valid && req_ch.ready;
   assign push_cmd     = cmd_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (take) begin
         hold_valid_in = 1'b1;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff.op  <= decode_mode(req_ch.mode);
         cmd_ff.ch  <= req_ch.char_in;
         cmd_ff.pos <= req_ch.position;
      end
   end
endmodule

`default_nettype wire

// File: rtl/gble_queue.sv
`default_nettype none

module gble_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gble_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output gble_pkg::cmd_type      head_cmd
);
   import gble_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] ptr);
      logic [QPTR_W-1:0] nxt;
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + QPTR_W'(1);
      end
      return nxt;
   endfunction

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

`default_nettype wire

// File: rtl/gble_back.sv
`default_nettype none

module gble_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire gble_pkg::cmd_type head_cmd,
   output logic                   pop,
   gble_rsp_if.source             rsp_ch
);
   import gble_pkg::*;

   localparam cnt_type CAP_CNT = CNT_W'(CAPACITY);

   back_state_type state_ff, state_in;
   cnt_type        lc_ff, lc_in;
   cnt_type        rc_ff, rc_in;
   cmd_type        cmd_ff;

   // Left and right stacks.
   char_type left_mem  [CAPACITY];
   char_type right_mem [CAPACITY];
   char_type left_rdata_ff, right_rdata_ff;

   logic     left_we, right_we;
   addr_type left_waddr, right_waddr, left_raddr, right_raddr;
   char_type left_wdata, right_wdata;

   logic       rsp_valid_ff, rsp_valid_in;
   char_type   char_out_ff;
   len_type    length_ff;
   len_type    cursor_ff;
   status_type status_ff;

   logic       rsp_load;
   char_type   rsp_char;
   status_type rsp_status;
   logic       go_data;
   logic       slot_free;

   cnt_type           head_pos, cur_pos, head_q;
   logic [SUM_W-1:0]  total;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign head_pos  = CNT_W'(head_cmd.pos);
   assign cur_pos   = CNT_W'(cmd_ff.pos);
   assign head_q    = head_pos - lc_ff;
   assign total     = SUM_W'(lc_ff) + SUM_W'(rc_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (go_data) begin
               state_in = BACK_DATA;
            end
         end
         BACK_DATA: state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase
   end

   // Datapath control.
   always_comb begin
      pop         = 1'b0;
      go_data     = 1'b0;
      lc_in       = lc_ff;
      rc_in       = rc_ff;
      left_we     = 1'b0;
      right_we    = 1'b0;
      left_waddr  = ADDR_W'(lc_ff);
      right_waddr = ADDR_W'(rc_ff);
      left_wdata  = head_cmd.ch;
      right_wdata = left_rdata_ff;
      left_raddr  = ADDR_W'(lc_ff - CNT_W'(1));
      right_raddr = ADDR_W'(rc_ff - CNT_W'(1));
      rsp_load    = 1'b0;
      rsp_char    = '0;
      rsp_status  = STATUS_OK;
      case (state_ff)
         BACK_IDLE: begin
            if (head_valid && slot_free) begin
               pop = 1'b1;
               case (head_cmd.op)
                  OP_INSERT: begin
                     rsp_load = 1'b1;
                     if (total >= SUM_W'(CAPACITY)) begin
                        rsp_status = STATUS_FULL;
                     end else begin
                        left_we = 1'b1;
                        lc_in   = lc_ff + CNT_W'(1);
                     end
                  end
                  OP_LEFT: begin
                     if (lc_ff == '0 || rc_ff >= CAP_CNT) begin
                        rsp_load   = 1'b1;
                        rsp_status = STATUS_BOUNDARY;
                     end else begin
                        go_data = 1'b1;
                     end
                  end
                  OP_RIGHT: begin
                     if (rc_ff == '0 || lc_ff >= CAP_CNT) begin
                        rsp_load   = 1'b1;
                        rsp_status = STATUS_BOUNDARY;
                     end else begin
                        go_data = 1'b1;
                     end
                  end
                  OP_BACK: begin
                     rsp_load = 1'b1;
                     if (lc_ff == '0) begin
                        rsp_status = STATUS_BOUNDARY;
                     end else begin
                        lc_in = lc_ff - CNT_W'(1);
                     end
                  end
                  OP_READ: begin
                     if (head_pos < lc_ff) begin
                        left_raddr = ADDR_W'(head_pos);
                        go_data    = 1'b1;
                     end else if (head_q < rc_ff) begin
                        // The right stack holds the text in reverse order.
                        right_raddr = ADDR_W'(rc_ff - CNT_W'(1) - head_q);
                        go_data     = 1'b1;
                     end else begin
                        rsp_load   = 1'b1;
                        rsp_status = STATUS_RANGE;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         BACK_DATA: begin
            rsp_load = 1'b1;
            case (cmd_ff.op)
               OP_LEFT: begin
                  right_we = 1'b1;
                  lc_in    = lc_ff - CNT_W'(1);
                  rc_in    = rc_ff + CNT_W'(1);
               end
               OP_RIGHT: begin
                  left_we    = 1'b1;
                  left_wdata = right_rdata_ff;
                  lc_in      = lc_ff + CNT_W'(1);
                  rc_in      = rc_ff - CNT_W'(1);
               end
               OP_READ: begin
                  rsp_char = (cur_pos < lc_ff) ? left_rdata_ff : right_rdata_ff;
               end
               default: begin
                  rsp_char = '0;
               end
            endcase
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         lc_ff        <= '0;
         rc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_cmd;
      end
      if (rsp_load) begin
         char_out_ff <= rsp_char;
         length_ff   <= len_type'(lc_in + rc_in);
         cursor_ff   <= len_type'(lc_in);
         status_ff   <= rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[left_waddr] <= left_wdata;
      end
      left_rdata_ff <= left_mem[left_raddr];
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[right_waddr] <= right_wdata;
      end
      right_rdata_ff <= right_mem[right_raddr];
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.char_out    = char_out_ff;
   assign rsp_ch.text_length = length_ff;
   assign rsp_ch.cursor      = cursor_ff;
   assign rsp_ch.status      = status_ff;
endmodule

`default_nettype wire

// File: rtl/gap_buffer_line_editor_core.sv
`default_nettype none
// An accepted request passes through the front holding register, the command queue and the
// back end to the response register; cursor moves and in-range reads also pass the data state.
// Throughput: one request per cycle for single-step requests while responses are taken; moves
// and in-range reads hold the back end in its data state for the registered read of the stack memory.
// Reset (synchronous, active high) empties the text, the queue and the response register;
// the stack memories are not cleared and need no clearing pass.

module gap_buffer_line_editor_core (
   input  wire logic  clock,
   input  wire logic  reset,
   gble_req_if.sink   req_ch,
   gble_rsp_if.source rsp_ch
);
   import gble_pkg::*;

   // The front stage registers each request and decodes its mode into an
   // operation; the queue decouples it from the back end, which owns both
   // stacks and the character counts.
   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   gble_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   gble_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // The back end executes one request at a time. A cursor move reads the top
   // of one stack and pushes it onto the other in the following cycle; a read
   // fetches from whichever stack holds the position. A new request is taken only
   // while the response register is empty or its response is being taken.
   gble_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );
endmodule

`default_nettype wire
